[rtl/bubble_damping_coefficient_defines.svh]
// Assertion macros for the bubble damping coefficient block.
// Used by the top level; expects clk and arst_n in scope.
`ifndef BUBBLE_DAMPING_COEFFICIENT_DEFINES_SVH
`define BUBBLE_DAMPING_COEFFICIENT_DEFINES_SVH

// implication checked at every clock edge out of reset
`define BDC_CHECK(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bdc check failed");

// invariant checked at every clock edge out of reset
`define BDC_HOLD(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("bdc invariant failed");

`endif

[rtl/bdc_pkg.sv]
// Package for the bubble damping coefficient block: word types, tag types,
// datapath widths and fixed-point constants. No dependencies.
`timescale 1ns / 1ps
package bdc_pkg;

	localparam int DIV_NW = 72;
	localparam int DIV_DW = 96;
	localparam int DIV_QW = 64;
	localparam int SQ_XW  = 64;
	localparam int SQ_RW  = 32;
	localparam int SQ_TW  = SQ_XW + 2;
	localparam int TAG_W  = 128;

	localparam logic [127:0] DV_WIDE  = (128'd89 << 88) / 128'd24950000;
	localparam logic [127:0] PHI_WIDE = (128'h3243F6A8885A308D * 128'd10000000) / 128'd9;
	localparam logic [DIV_NW-1:0] DV_NUM  = DIV_NW'(DV_WIDE);
	localparam logic [DIV_NW-1:0] PHI_NUM = DIV_NW'(PHI_WIDE >> 19);

	// ceil(2^51 / 1497): exact floor divide by 1497 for 40-bit numerators
	localparam logic [40:0] DR_RECIP  = 41'(((128'd1 << 51) + 128'd1496) / 128'd1497);
	localparam logic [59:0] PHI_CAP   = 60'hFFF_FFFF_FFFF_FFFF;
	localparam logic [59:0] PHI_FLOOR = 60'h4000_0000;
	localparam logic [59:0] PHI_LIFT  = 60'h4000_0001;
	localparam logic [59:0] PHI_3Q    = 60'h3000_0000;
	localparam logic [31:0] D_CAP     = 32'h8000_0000;
	localparam logic [34:0] TH_REF    = 35'h10_0000;
	localparam logic [63:0] SQ_BIAS   = 64'h4_0000_0000;
	localparam logic [31:0] ROOT_MIN  = 32'h0002_0000;

	typedef struct packed {
		logic [31:0] radius;
		logic [31:0] omega;
	} in_t;

	typedef struct packed {
		logic [31:0] beta;
		logic        status;
	} out_t;

	typedef struct packed {
		logic        vld;
		logic [31:0] w;
		logic        zero;
		logic [30:0] dr;
		logic [95:0] dv_den;
	} front_t;

	typedef logic [TAG_W-1:0] tag_t;

	typedef struct packed {
		logic [31:0] w;
		logic        zero;
		logic [30:0] dr;
	} tag_phi_t;

	typedef struct packed {
		logic [31:0] w;
		logic        zero;
		logic [32:0] drdv;
		logic [61:0] den_th;
	} tag_sq1_t;

	typedef struct packed {
		logic [31:0] w;
		logic        zero;
		logic [32:0] drdv;
		logic        neg;
	} tag_dth_t;

	typedef struct packed {
		logic        zero;
		logic        pos;
		logic [63:0] wd;
	} tag_sq2_t;

	typedef struct packed {
		logic zero;
		logic pos;
	} tag_bt_t;

endpackage

[rtl/bubble_damping_coefficient.sv]
// Bubble damping coefficient, top level: radiative, viscous and thermal terms.
// Depends on bdc_pkg, bdc_front, bdc_div, bdc_sqrt and the defines header.
`timescale 1ns / 1ps
// One word enters per clock whenever start is high; busy is always low and the
// block never stalls. Each result appears on result with done high for one cycle,
// in order. Each word passes through the three chained 64-stage dividers
// (damping terms, thermal term, final rate) and the two 32-stage square
// roots; the receiver must take every result as it comes.
module bubble_damping_coefficient (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  bdc_pkg::in_t  item,
	output logic          done,
	output bdc_pkg::out_t result
);
	import bdc_pkg::*;
	`include "bubble_damping_coefficient_defines.svh"

	front_t            fr;
	logic              dv_vld, dv_ovf, ph_vld, ph_ovf;
	logic [DIV_QW-1:0] dv_q, ph_q;
	tag_t              ph_tag;
	tag_phi_t          tp;
	logic [31:0]       dv_sat;
	logic [59:0]       phi_sat, phi_adj;

	logic              vld_s5, zero_s5;
	logic [32:0]       drdv_s5;
	logic [59:0]       phi_s5;
	logic [31:0]       w_s5;
	logic [59:0]       phi_off;
	tag_sq1_t          sq1_in, t1;
	logic              s1_vld;
	logic [SQ_RW-1:0]  s1_root;
	tag_t              s1_tag;

	logic [34:0]       six;
	logic              neg;
	logic [34:0]       diff;
	logic              vld_s6, neg_s6, zero_s6;
	logic [62:0]       mag_s6;
	logic [61:0]       den_s6;
	logic [32:0]       drdv_s6;
	logic [31:0]       w_s6;

	logic              th_vld;
	logic [DIV_QW-1:0] th_q;
	tag_t              th_tag;
	tag_dth_t          t2;
	logic signed [35:0] dth_sg, tot;

	logic              vld_s7, pos_s7, zero_s7;
	logic [31:0]       d_s7, w_s7;
	logic              vld_s8, pos_s8, zero_s8;
	logic [63:0]       dd_s8, wd_s8;

	logic              q2_vld;
	logic [SQ_RW-1:0]  q2_root;
	tag_t              q2_tag;
	tag_sq2_t          t3;
	logic              bt_vld;
	logic [DIV_QW-1:0] bt_q;
	tag_t              bt_tag;
	tag_bt_t           t4;

	logic              done_q;
	out_t              result_q;

	assign busy = 1'b0;

	bdc_front u_front (
		.clk(clk), .arst_n(arst_n), .vld(start && !busy), .item(item), .fr(fr)
	);

	bdc_div u_dv (
		.clk(clk), .arst_n(arst_n), .vld(fr.vld), .num(DV_NUM), .den(fr.dv_den),
		.tag('0), .q_vld(dv_vld), .quo(dv_q), .ovf(dv_ovf), .q_tag()
	);

	bdc_div u_phi (
		.clk(clk), .arst_n(arst_n), .vld(fr.vld), .num(PHI_NUM), .den(DIV_DW'(fr.w)),
		.tag(TAG_W'(tag_phi_t'{w: fr.w, zero: fr.zero, dr: fr.dr})),
		.q_vld(ph_vld), .quo(ph_q), .ovf(ph_ovf), .q_tag(ph_tag)
	);

	assign tp      = tag_phi_t'(ph_tag[$bits(tag_phi_t)-1:0]);
	assign dv_sat  = (dv_ovf || dv_q > 64'(D_CAP)) ? D_CAP : dv_q[31:0];
	assign phi_sat = (ph_ovf || ph_q > 64'(PHI_CAP)) ? PHI_CAP : ph_q[59:0];
	assign phi_adj = (phi_sat <= PHI_FLOOR) ? PHI_LIFT : phi_sat;

	always_ff @(posedge clk) begin
		drdv_s5 <= 33'(tp.dr) + 33'(dv_sat);
		phi_s5  <= phi_adj;
		w_s5    <= tp.w;
		zero_s5 <= tp.zero;
	end

	// thermal term: sqrt(phi - 3) and denominator 3*(phi - 4)
	assign phi_off = phi_s5 - PHI_FLOOR;
	assign sq1_in  = '{w: w_s5, zero: zero_s5, drdv: drdv_s5,
		den_th: 62'({phi_off, 1'b0}) + 62'(phi_off)};

	bdc_sqrt u_sq_th (
		.clk(clk), .arst_n(arst_n), .vld(vld_s5), .x({phi_s5 - PHI_3Q, 4'b0}),
		.tag(TAG_W'(sq1_in)), .r_vld(s1_vld), .root(s1_root), .r_tag(s1_tag)
	);

	assign t1   = tag_sq1_t'(s1_tag[$bits(tag_sq1_t)-1:0]);
	assign six  = 35'({s1_root, 2'b0}) + 35'({s1_root, 1'b0});
	assign neg  = six < TH_REF;
	assign diff = neg ? TH_REF - six : six - TH_REF;

	always_ff @(posedge clk) begin
		mag_s6  <= {diff, 28'b0};
		neg_s6  <= neg;
		den_s6  <= t1.den_th;
		drdv_s6 <= t1.drdv;
		w_s6    <= t1.w;
		zero_s6 <= t1.zero;
	end

	bdc_div u_dth (
		.clk(clk), .arst_n(arst_n), .vld(vld_s6), .num(DIV_NW'(mag_s6)),
		.den(DIV_DW'(den_s6)),
		.tag(TAG_W'(tag_dth_t'{w: w_s6, zero: zero_s6, drdv: drdv_s6, neg: neg_s6})),
		.q_vld(th_vld), .quo(th_q), .ovf(), .q_tag(th_tag)
	);

	assign t2     = tag_dth_t'(th_tag[$bits(tag_dth_t)-1:0]);
	assign dth_sg = t2.neg ? -$signed({2'b0, th_q[33:0]}) : $signed({2'b0, th_q[33:0]});
	assign tot    = $signed({3'b0, t2.drdv}) + dth_sg;

	always_ff @(posedge clk) begin
		pos_s7  <= tot > 36'sd0;
		d_s7    <= (tot <= 36'sd0) ? '0 :
			(tot > $signed(36'(D_CAP))) ? D_CAP : tot[31:0];
		w_s7    <= t2.w;
		zero_s7 <= t2.zero;
		dd_s8   <= d_s7 * d_s7;
		wd_s8   <= w_s7 * d_s7;
		pos_s8  <= pos_s7;
		zero_s8 <= zero_s7;
	end

	bdc_sqrt u_sq_d (
		.clk(clk), .arst_n(arst_n), .vld(vld_s8), .x(dd_s8 + SQ_BIAS),
		.tag(TAG_W'(tag_sq2_t'{zero: zero_s8, pos: pos_s8, wd: wd_s8})),
		.r_vld(q2_vld), .root(q2_root), .r_tag(q2_tag)
	);

	assign t3 = tag_sq2_t'(q2_tag[$bits(tag_sq2_t)-1:0]);

	bdc_div u_beta (
		.clk(clk), .arst_n(arst_n), .vld(q2_vld), .num(DIV_NW'(t3.wd)),
		.den(DIV_DW'(q2_root)), .tag(TAG_W'(tag_bt_t'{zero: t3.zero, pos: t3.pos})),
		.q_vld(bt_vld), .quo(bt_q), .ovf(), .q_tag(bt_tag)
	);

	assign t4 = tag_bt_t'(bt_tag[$bits(tag_bt_t)-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s5 <= ph_vld;
			vld_s6 <= s1_vld;
			vld_s7 <= th_vld;
			vld_s8 <= vld_s7;
			done_q <= bt_vld;
		end
	end

	always_ff @(posedge clk) begin
		result_q.beta   <= (t4.pos && !t4.zero) ? bt_q[31:0] : '0;
		result_q.status <= t4.zero;
	end

	assign done   = done_q;
	assign result = result_q;

	`BDC_HOLD(a_div_align, dv_vld == ph_vld)
	`BDC_CHECK(a_root_floor, q2_vld, q2_root >= ROOT_MIN)
	`BDC_CHECK(a_status_zero, done, !(result.status && result.beta != '0))

endmodule

[rtl/bdc_front.sv]
// Input capture and multiplier pipeline: w*r and w*r*r in 32x32 partials,
// radiative term by reciprocal multiply. Depends on bdc_pkg.
`timescale 1ns / 1ps
module bdc_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           vld,
	input  bdc_pkg::in_t   item,
	output bdc_pkg::front_t fr
);
	import bdc_pkg::*;

	logic        vld_s1, vld_s2, vld_s3, vld_s4;
	logic [31:0] r_s1, w_s1, r_s2, w_s2, w_s3, w_s4;
	logic        zero_s1, zero_s2, zero_s3, zero_s4;
	logic [63:0] wr_s2, lo_s3, hi_s3;
	logic [60:0] prh_s3;
	logic [59:0] prl_s3;
	logic [80:0] drp;
	logic [95:0] den_s4;
	logic [30:0] dr_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	assign drp = {prh_s3, 20'b0} + {21'b0, prl_s3};

	always_ff @(posedge clk) begin
		r_s1    <= item.radius;
		w_s1    <= item.omega;
		zero_s1 <= (item.radius == '0) || (item.omega == '0);
		wr_s2   <= w_s1 * r_s1;
		r_s2    <= r_s1;
		w_s2    <= w_s1;
		zero_s2 <= zero_s1;
		lo_s3   <= wr_s2[31:0] * r_s2;
		hi_s3   <= wr_s2[63:32] * r_s2;
		prh_s3  <= wr_s2[63:24] * DR_RECIP[40:20];
		prl_s3  <= wr_s2[63:24] * DR_RECIP[19:0];
		w_s3    <= w_s2;
		zero_s3 <= zero_s2;
		den_s4  <= {hi_s3, 32'b0} + {32'b0, lo_s3};
		dr_s4   <= {1'b0, drp[80:51]};
		w_s4    <= w_s3;
		zero_s4 <= zero_s3;
	end

	assign fr = '{vld: vld_s4, w: w_s4, zero: zero_s4, dr: dr_s4, dv_den: den_s4};

endmodule

[rtl/bdc_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with a tag
// carried alongside. Flags a quotient that does not fit. Depends on bdc_pkg.
`timescale 1ns / 1ps
module bdc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       vld,
	input  logic [bdc_pkg::DIV_NW-1:0] num,
	input  logic [bdc_pkg::DIV_DW-1:0] den,
	input  bdc_pkg::tag_t              tag,
	output logic                       q_vld,
	output logic [bdc_pkg::DIV_QW-1:0] quo,
	output logic                       ovf,
	output bdc_pkg::tag_t              q_tag
);
	import bdc_pkg::*;

	localparam int CW = DIV_DW + DIV_QW;

	logic [DIV_QW:0]   vld_s;
	logic [DIV_NW-1:0] rem_s [0:DIV_QW];
	logic [DIV_DW-1:0] den_s [0:DIV_QW];
	logic [DIV_QW-1:0] quo_s [0:DIV_QW];
	logic              ovf_s [0:DIV_QW];
	tag_t              tag_s [0:DIV_QW];
	logic [CW-1:0]     trial [0:DIV_QW-1];
	logic [DIV_QW-1:0] take;

	always_comb begin
		for (int i = 0; i < DIV_QW; i++) begin
			trial[i] = {{DIV_QW{1'b0}}, den_s[i]} << (DIV_QW - 1 - i);
			take[i]  = {{(CW - DIV_NW){1'b0}}, rem_s[i]} >= trial[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[DIV_QW-1:0], vld};
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= num;
		den_s[0] <= den;
		quo_s[0] <= '0;
		ovf_s[0] <= {{(DIV_DW - DIV_NW + DIV_QW){1'b0}}, num[DIV_NW-1:DIV_QW]} >= den;
		tag_s[0] <= tag;
		for (int i = 0; i < DIV_QW; i++) begin
			rem_s[i+1] <= take[i] ? rem_s[i] - trial[i][DIV_NW-1:0] : rem_s[i];
			den_s[i+1] <= den_s[i];
			quo_s[i+1] <= {quo_s[i][DIV_QW-2:0], take[i]};
			ovf_s[i+1] <= ovf_s[i];
			tag_s[i+1] <= tag_s[i];
		end
	end

	assign q_vld = vld_s[DIV_QW];
	assign quo   = quo_s[DIV_QW];
	assign ovf   = ovf_s[DIV_QW];
	assign q_tag = tag_s[DIV_QW];

endmodule

[rtl/bdc_sqrt.sv]
// Pipelined integer square root (floor), one root bit per stage, with a tag
// carried alongside. Depends on bdc_pkg.
`timescale 1ns / 1ps
module bdc_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      vld,
	input  logic [bdc_pkg::SQ_XW-1:0] x,
	input  bdc_pkg::tag_t             tag,
	output logic                      r_vld,
	output logic [bdc_pkg::SQ_RW-1:0] root,
	output bdc_pkg::tag_t             r_tag
);
	import bdc_pkg::*;

	logic [SQ_RW:0]    vld_s;
	logic [SQ_XW-1:0]  rem_s  [0:SQ_RW];
	logic [SQ_RW-1:0]  root_s [0:SQ_RW];
	tag_t              tag_s  [0:SQ_RW];
	logic [SQ_TW-1:0]  trial  [0:SQ_RW-1];
	logic [SQ_RW-1:0]  take;

	// (root + 2^b)^2 - root^2 = root*2^(b+1) + 2^(2b)
	always_comb begin
		for (int i = 0; i < SQ_RW; i++) begin
			trial[i] = ({{(SQ_TW - SQ_RW){1'b0}}, root_s[i]} << (SQ_RW - i))
				+ (SQ_TW'(1) << (2 * (SQ_RW - 1 - i)));
			take[i]  = {2'b0, rem_s[i]} >= trial[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[SQ_RW-1:0], vld};
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= x;
		root_s[0] <= '0;
		tag_s[0]  <= tag;
		for (int i = 0; i < SQ_RW; i++) begin
			rem_s[i+1]  <= take[i] ? rem_s[i] - trial[i][SQ_XW-1:0] : rem_s[i];
			root_s[i+1] <= take[i] ? root_s[i] | (SQ_RW'(1) << (SQ_RW - 1 - i)) : root_s[i];
			tag_s[i+1]  <= tag_s[i];
		end
	end

	assign r_vld = vld_s[SQ_RW];
	assign root  = root_s[SQ_RW];
	assign r_tag = tag_s[SQ_RW];

endmodule

[bench/bdc_checker.sv]
// Checker for the bubble damping coefficient block: watches the word channels,
// predicts each damping rate in fixed point and compares in order. Needs bdc_pkg.
`timescale 1ns / 1ps
module bdc_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          busy,
	input  bdc_pkg::in_t  item,
	input  logic          done,
	input  bdc_pkg::out_t result,
	output int            fail_count,
	output int            pending
);
	import bdc_pkg::*;

	localparam logic [63:0]  PI_FIX    = 64'h3243F6A8885A308D;
	localparam logic [63:0]  DAMP_CAP  = 64'h8000_0000;
	localparam logic [63:0]  PHI_LIMIT = 64'h0FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0]  PHI_MIN   = 64'h4000_0000;

	out_t beta_expect_q[$];

	function automatic logic [63:0] int_root(input logic [63:0] x);
		logic [63:0] rem, res, b;
		rem = x;
		res = 0;
		b = 64'h1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (rem >= res + b) begin
				rem = rem - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic out_t predict_damping(input in_t v);
		out_t o;
		logic [127:0] wide;
		logic [63:0] r, w, dr, dv, phi, s, den, mag, d, s2;
		longint signed dth, total;
		r = {32'd0, v.radius};
		w = {32'd0, v.omega};
		o.beta = '0;
		o.status = 1'b0;
		if (r == 0 || w == 0) begin
			o.status = 1'b1;
			return o;
		end
		dr = ((w * r) >> 24) / 64'd1497;
		wide = (128'd89 << 88) / 128'd24950000;
		wide = wide / w;
		wide = wide / r;
		wide = wide / r;
		dv = (wide > DAMP_CAP) ? DAMP_CAP : wide[63:0];
		wide = {64'd0, PI_FIX} * 128'd10000000;
		wide = wide / 128'd9;
		wide = wide / w;
		wide = wide / 128'd524288;
		phi = (wide > PHI_LIMIT) ? PHI_LIMIT : wide[63:0];
		if (phi <= PHI_MIN)
			phi = PHI_MIN + 1;
		s = int_root((phi - (64'd3 << 28)) << 4);
		den = 64'd3 * (phi - PHI_MIN);
		if (64'd6 * s >= (64'd1 << 20)) begin
			mag = (64'd6 * s - (64'd1 << 20)) << 28;
			dth = longint'(mag / den);
		end else begin
			mag = ((64'd1 << 20) - 64'd6 * s) << 28;
			dth = -longint'(mag / den);
		end
		total = longint'(dr) + longint'(dv) + dth;
		if (total <= 0)
			return o;
		d = total;
		if (d > DAMP_CAP)
			d = DAMP_CAP;
		s2 = int_root(d * d + (64'd1 << 34));
		o.beta = 32'((w * d) / s2);
		return o;
	endfunction

	assign pending = beta_expect_q.size();

	always @(posedge clk or negedge arst_n) begin
		out_t e;
		if (!arst_n) begin
			fail_count <= 0;
			beta_expect_q.delete();
		end else begin
			if (start && !busy)
				beta_expect_q.push_back(predict_damping(item));
			if (done) begin
				if (beta_expect_q.size() == 0) begin
					$display("%0t: unexpected word beta=%h status=%b", $time,
						result.beta, result.status);
					fail_count <= fail_count + 1;
				end else begin
					e = beta_expect_q.pop_front();
					if (e.beta !== result.beta || e.status !== result.status) begin
						$display("%0t: mismatch expected beta=%h status=%b, actual beta=%h status=%b",
							$time, e.beta, e.status, result.beta, result.status);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

[bench/testbench.sv]
// Top of the bubble damping coefficient bench: clock, reset, stimulus, verdict.
// Needs bdc_pkg, bubble_damping_coefficient and bdc_checker.
`timescale 1ns / 1ps
module testbench;
	import bdc_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_t  item = '0;
	logic done;
	out_t result;
	int   fail_count;
	int   pending;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	bubble_damping_coefficient dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.item(item), .done(done), .result(result)
	);

	bdc_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.item(item), .done(done), .result(result),
		.fail_count(fail_count), .pending(pending)
	);

	task automatic send_word(input logic [31:0] r, input logic [31:0] w, input bit quiet);
		int gap;
		@(negedge clk);
		start <= 1'b1;
		item <= '{radius: r, omega: w};
		do @(posedge clk); while (busy);
		if (!quiet && $urandom_range(99) < 7) begin
			gap = $urandom_range(4, 1);
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	function automatic logic [31:0] spread_val();
		case ($urandom_range(3))
			0: return $urandom();
			1: return $urandom() >> $urandom_range(31);
			2: return $urandom() >> $urandom_range(31, 16);
			default: return $urandom() >> $urandom_range(15);
		endcase
	endfunction

	initial begin
		logic [31:0] r, w;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		send_word(32'd1, 32'd1, 1'b0);
		send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		send_word(32'd0, 32'd5, 1'b0);
		send_word(32'd5, 32'd0, 1'b0);
		send_word(32'd0, 32'd0, 1'b0);
		send_word(32'hFFFF_FFFF, 32'd1, 1'b0);
		send_word(32'd1, 32'hFFFF_FFFF, 1'b0);
		send_word(32'd4294967, 32'd4825486, 1'b0);
		send_word(32'd429497, 32'd48254860, 1'b0);
		send_word(32'd42949673, 32'd482549, 1'b0);
		send_word(32'h0000_4000, 32'h00FF_FFFF, 1'b0);
		send_word(32'h0010_0000, 32'hFFFF_FFFF, 1'b0);
		send_word(32'h8000_0000, 32'h8000_0000, 1'b0);
		send_word(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
		send_word(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
		send_word(32'd2, 32'd256, 1'b0);
		send_word(32'd100000, 32'd2560, 1'b0);
		for (int i = 0; i < 1050; i++) begin
			r = spread_val();
			w = spread_val();
			if ($urandom_range(49) == 0)
				r = 0;
			if ($urandom_range(49) == 0)
				w = 0;
			send_word(r, w, i >= 300 && i < 600);
		end
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#500000;
		$display("CHECK FAILED");
		$finish;
	end
endmodule

[sim.f]
+incdir+rtl
rtl/bdc_pkg.sv
rtl/bdc_front.sv
rtl/bdc_div.sv
rtl/bdc_sqrt.sv
rtl/bubble_damping_coefficient.sv
bench/bdc_checker.sv
bench/testbench.sv
